FILE: rtl/core/sobel_edge_magnitude_rgb_unit_macros.svh
// ----------------------------------------------------------------------------
// sobel edge magnitude assertion macros
// shared property forms for the unit's checks
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH

// same-cycle implication
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared constants, types and codes of the sobel edge magnitude unit
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int IROW_W     = ROW_W + 1;
    localparam int WID_W      = 11;
    localparam int PIX_W      = 24;
    localparam int SUM_W      = 21;
    localparam int ROOT_W     = 22;
    localparam int ROOT_STEPS = 11;
    localparam int CNT_W      = 4;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(768);

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GRAD,
        S_SQUARE,
        S_START,
        S_ROOT,
        S_OUT
    } sem_state_t;

    typedef struct packed {
        logic take;
        logic shift;
        logic grad;
        logic square;
        logic root_start;
        logic root_step;
        logic out_load;
    } sem_cmd_t;

    typedef struct packed {
        logic drop;
        logic produce;
        logic out_free;
    } sem_stat_t;

endpackage

FILE: rtl/core/sem_root.sv
// ----------------------------------------------------------------------------
// sem_root
// bit-pair integer square root, rounded to nearest and clamped to 255
// ----------------------------------------------------------------------------
module sem_root (
    input  logic                      aclk,
    input  logic                      start,
    input  logic                      step,
    input  logic [sem_pkg::SUM_W-1:0] s_in,
    output logic [7:0]                mag
);

    logic [sem_pkg::ROOT_W-1:0] x_reg, r_reg, bit_reg;
    logic [sem_pkg::ROOT_W-1:0] x_next, r_next, bit_next;
    logic [sem_pkg::ROOT_W-1:0] trial, rnd;

    always_comb begin
        trial    = r_reg + bit_reg;
        x_next   = x_reg;
        r_next   = r_reg >> 1;
        bit_next = bit_reg >> 2;
        if (x_reg >= trial) begin
            x_next = x_reg - trial;
            r_next = (r_reg >> 1) + bit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= sem_pkg::ROOT_W'(s_in);
            r_reg   <= '0;
            bit_reg <= sem_pkg::ROOT_W'(1) << (2 * (sem_pkg::ROOT_STEPS - 1));
        end else if (step) begin
            x_reg   <= x_next;
            r_reg   <= r_next;
            bit_reg <= bit_next;
        end
    end

    assign rnd = r_reg + ((x_reg > r_reg) ? sem_pkg::ROOT_W'(1) : sem_pkg::ROOT_W'(0));
    assign mag = (rnd > sem_pkg::ROOT_W'(255)) ? 8'hff : rnd[7:0];

endmodule

FILE: rtl/core/sem_datapath.sv
// ----------------------------------------------------------------------------
// sem_datapath
// line stores, 3x3 window, position counters, gradients, roots, result beat
// ----------------------------------------------------------------------------
module sem_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sem_pkg::sem_cmd_t         cmd,
    output sem_pkg::sem_stat_t        stat,
    input  logic                      cfg_restart,
    input  logic [sem_pkg::WID_W-1:0] cfg_width,
    input  logic [sem_pkg::ROW_W-1:0] cfg_height,
    input  logic                      s_req_type,
    input  logic [7:0]                s_in_red,
    input  logic [7:0]                s_in_green,
    input  logic [7:0]                s_in_blue,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_edge_red,
    output logic [7:0]                m_edge_green,
    output logic [7:0]                m_edge_blue,
    output logic                      m_row_end,
    output logic                      m_frame_end
);

    logic [sem_pkg::PIX_W-1:0] line_a [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] line_b [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] rd_a_reg, rd_b_reg, pix_reg;
    logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_reg;

    logic [sem_pkg::COL_W-1:0]  in_col_reg, out_col_reg, last_col;
    logic [sem_pkg::IROW_W-1:0] in_row_reg;
    logic [sem_pkg::ROW_W-1:0]  out_row_reg, last_row;
    logic [sem_pkg::WID_W-1:0]  eff_w;
    logic                       pixel_ok, frame_hit;

    logic [2:0][2:0] keep;
    logic signed [2:0][11:0] gx, gy;
    logic signed [2:0][11:0] gx_reg, gy_reg;
    logic [2:0][sem_pkg::SUM_W-1:0] sum_reg;
    logic [2:0][7:0] mag;
    logic [7:0] edge_r_reg, edge_g_reg, edge_b_reg;
    logic row_end_reg, frame_end_reg, m_valid_reg;

    always_comb begin
        eff_w = cfg_width;
        if (cfg_width == '0) eff_w = sem_pkg::WID_W'(1);
        else if (cfg_width > sem_pkg::WID_W'(sem_pkg::MAX_WIDTH))
            eff_w = sem_pkg::WID_W'(sem_pkg::MAX_WIDTH);
    end

    assign last_col  = sem_pkg::COL_W'(eff_w - sem_pkg::WID_W'(1));
    assign last_row  = (cfg_height == '0) ? '0 : cfg_height - sem_pkg::ROW_W'(1);
    assign pixel_ok  = (in_row_reg <= sem_pkg::IROW_W'(last_row));
    assign frame_hit = (out_row_reg == last_row) && (out_col_reg == last_col);

    assign stat.drop     = (s_req_type == sem_pkg::REQ_DRAIN) && pixel_ok;
    assign stat.produce  = (in_row_reg > sem_pkg::IROW_W'(1)) ||
                           ((in_row_reg == sem_pkg::IROW_W'(1)) && (in_col_reg != '0));
    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rd_a_reg <= line_a[in_col_reg];
            rd_b_reg <= line_b[in_col_reg];
            pix_reg  <= ((s_req_type == sem_pkg::REQ_PIXEL) && pixel_ok) ?
                        {s_in_blue, s_in_green, s_in_red} : '0;
        end
        if (cmd.shift) begin
            line_a[in_col_reg] <= pix_reg;
            line_b[in_col_reg] <= rd_a_reg;
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= {pix_reg, rd_a_reg, rd_b_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart || (cmd.out_load && frame_hit)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (cmd.shift) begin
                if (in_col_reg == last_col) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + sem_pkg::IROW_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + sem_pkg::COL_W'(1);
                end
            end
            if (cmd.out_load) begin
                if (out_col_reg == last_col) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + sem_pkg::ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + sem_pkg::COL_W'(1);
                end
            end
        end
    end

    // window column 1 middle row is the centre pixel; rows: 0 top, 2 bottom
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                keep[c][r] = !((c == 0) && (out_col_reg == '0)) &&
                             !((c == 2) && (out_col_reg == last_col)) &&
                             !((r == 0) && (out_row_reg == '0)) &&
                             !((r == 2) && (out_row_reg == last_row));
            end
        end
    end

    always_comb begin
        logic signed [2:0][2:0][11:0] v;
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    v[c][r] = keep[c][r] ? $signed({4'b0, win_reg[c][r][8*ch +: 8]}) : 12'sd0;
                end
            end
            gx[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) -
                     (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
            gy[ch] = (v[0][2] + (v[1][2] <<< 1) + v[2][2]) -
                     (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
        end
    end

    always_ff @(posedge aclk) begin
        logic [10:0] ax, ay;
        logic [21:0] px, py;
        if (cmd.grad) begin
            gx_reg <= gx;
            gy_reg <= gy;
        end
        if (cmd.square) begin
            for (int ch = 0; ch < 3; ch++) begin
                ax = gx_reg[ch][11] ? 11'(-gx_reg[ch]) : gx_reg[ch][10:0];
                ay = gy_reg[ch][11] ? 11'(-gy_reg[ch]) : gy_reg[ch][10:0];
                px = ax * ax;
                py = ay * ay;
                sum_reg[ch] <= sem_pkg::SUM_W'(px + py);
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_root
        sem_root u_root (
            .aclk  (aclk),
            .start (cmd.root_start),
            .step  (cmd.root_step),
            .s_in  (sum_reg[ch]),
            .mag   (mag[ch])
        );
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            edge_r_reg    <= mag[0];
            edge_g_reg    <= mag[1];
            edge_b_reg    <= mag[2];
            row_end_reg   <= (out_col_reg == last_col);
            frame_end_reg <= frame_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_red   = edge_r_reg;
    assign m_edge_green = edge_g_reg;
    assign m_edge_blue  = edge_b_reg;
    assign m_row_end    = row_end_reg;
    assign m_frame_end  = frame_end_reg;

endmodule

FILE: rtl/core/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// per-beat sequencer: window update, gradient, square, root, result load
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_rgb_unit_macros.svh"

module sem_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sem_pkg::sem_stat_t stat,
    output sem_pkg::sem_cmd_t  cmd
);

    sem_pkg::sem_state_t state_reg, state_next;
    logic [sem_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            sem_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !stat.drop) begin
                    cmd.take   = 1'b1;
                    state_next = sem_pkg::S_READ;
                end
            end
            sem_pkg::S_READ: begin
                cmd.shift  = 1'b1;
                state_next = stat.produce ? sem_pkg::S_GRAD : sem_pkg::S_IDLE;
            end
            sem_pkg::S_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = sem_pkg::S_SQUARE;
            end
            sem_pkg::S_SQUARE: begin
                cmd.square = 1'b1;
                state_next = sem_pkg::S_START;
            end
            sem_pkg::S_START: begin
                cmd.root_start = 1'b1;
                cnt_next       = '0;
                state_next     = sem_pkg::S_ROOT;
            end
            sem_pkg::S_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + sem_pkg::CNT_W'(1);
                if (cnt_reg == sem_pkg::CNT_W'(sem_pkg::ROOT_STEPS - 1)) begin
                    state_next = sem_pkg::S_OUT;
                end
            end
            sem_pkg::S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sem_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sem_pkg::S_IDLE;
            end
        endcase
    end

    `SEM_ASSERT_NOW(a_load_free, cmd.out_load, stat.out_free, "result loaded over a waiting beat")
    `SEM_ASSERT_NEXT(a_take_read, cmd.take, state_reg == sem_pkg::S_READ, "take not followed by read")
    `SEM_ASSERT_NEXT(a_root_end, (state_reg == sem_pkg::S_ROOT) && (cnt_reg == sem_pkg::CNT_W'(sem_pkg::ROOT_STEPS - 1)), state_reg == sem_pkg::S_OUT, "root did not finish on time")

endmodule

FILE: rtl/core/sobel_edge_magnitude_rgb_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit
// 3x3 sobel gradient magnitude per rgb channel over a raster pixel stream
//
// channel  ports              beat
// input    s_valid/s_ready    req_type, red, green, blue
// output   m_valid/m_ready    edge red/green/blue, row_end, frame_end
// config   apb psel/penable   0x0 image_width, 0x4 image_height
//
// a result beat: take, shift, gradient, square, root start, 11-step root, load
// a beat giving no result ends after its shift; an ignored drain is dropped
// synchronous active-low reset, no clearing pass; stale line data is masked
// a waiting result stalls the sequencer only at its load step
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_edge_red,
    output logic [7:0]  m_edge_green,
    output logic [7:0]  m_edge_blue,
    output logic        m_row_end,
    output logic        m_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [sem_pkg::WID_W-1:0] width_reg;
    logic [sem_pkg::ROW_W-1:0] height_reg;
    logic                      cfg_wr;
    sem_pkg::sem_cmd_t         cmd;
    sem_pkg::sem_stat_t        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == sem_pkg::REG_WIDTH) width_reg <= pwdata[sem_pkg::WID_W-1:0];
            else height_reg <= pwdata[sem_pkg::ROW_W-1:0];
        end
    end

    assign prdata = (paddr[2] == sem_pkg::REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    sem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sem_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_restart  (cfg_wr),
        .cfg_width    (width_reg),
        .cfg_height   (height_reg),
        .s_req_type   (s_req_type),
        .s_in_red     (s_in_red),
        .s_in_green   (s_in_green),
        .s_in_blue    (s_in_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_red   (m_edge_red),
        .m_edge_green (m_edge_green),
        .m_edge_blue  (m_edge_blue),
        .m_row_end    (m_row_end),
        .m_frame_end  (m_frame_end)
    );

endmodule

FILE: bench/sobel_edge_magnitude_rgb_unit_test.sv
// ----------------------------------------------------------------------------
// sobel edge magnitude unit testbench
// streams rgb frames of many sizes through the unit, predicts each edge beat
// from a local window model and checks every result beat field by field
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit_test;

    localparam int RING = 2 * sem_pkg::MAX_WIDTH + 3;
    localparam int SETTLE = 40;

    typedef struct {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_beat_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } edge_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_in_red;
    logic [7:0]  s_in_green;
    logic [7:0]  s_in_blue;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_edge_red;
    logic [7:0]  m_edge_green;
    logic [7:0]  m_edge_blue;
    logic        m_row_end;
    logic        m_frame_end;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sobel_edge_magnitude_rgb_unit dut (.*);

    pixel_beat_t pending_pixels[$];
    edge_beat_t  edge_expected[$];

    logic [23:0] line_ring [RING];
    int          ring_slot;
    int          col_pos;
    int          row_pos;
    int          cfg_width;
    int          cfg_height;

    int send_idle;
    int recv_idle;
    int mismatches;
    int edges_checked;
    int frames_closed;
    int items_sent;
    int config_writes;
    bit timed_out;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int round_root(int s);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= s) r++;
        if (s - r * r > r) r++;
        return r > 255 ? 255 : r;
    endfunction

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        return cfg_width > sem_pkg::MAX_WIDTH ? sem_pkg::MAX_WIDTH : cfg_width;
    endfunction

    function automatic void restart_frame();
        ring_slot = 0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void predict_edge(pixel_beat_t b);
        int w, h, total, t, p, pr, pc, rr, cc, d, slot, newest, v;
        int gx[3];
        int gy[3];
        bit is_pixel;
        edge_beat_t e;
        w = eff_width();
        h = cfg_height == 0 ? 1 : cfg_height;
        total = w * h;
        t = row_pos * w + col_pos;
        is_pixel = (b.req_type == sem_pkg::REQ_PIXEL) && (t < total);
        if (!is_pixel && t < total) return;
        newest = ring_slot;
        line_ring[newest] = is_pixel ? {b.red, b.green, b.blue} : 24'h0;
        ring_slot = (newest + 1) % RING;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        p = t - w - 1;
        if (p < 0 || p >= total) return;
        pr = p / w;
        pc = p % w;
        for (int ch = 0; ch < 3; ch++) begin
            gx[ch] = 0;
            gy[ch] = 0;
        end
        for (int k = -1; k <= 1; k++) begin
            for (int l = -1; l <= 1; l++) begin
                rr = pr + k;
                cc = pc + l;
                if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
                d = t - (rr * w + cc);
                if (d < 0 || d >= RING) continue;
                slot = (newest + RING - d) % RING;
                for (int ch = 0; ch < 3; ch++) begin
                    v = line_ring[slot][23 - 8 * ch -: 8];
                    gx[ch] += v * l * (k == 0 ? 2 : 1);
                    gy[ch] += v * k * (l == 0 ? 2 : 1);
                end
            end
        end
        e.red = 8'(round_root(gx[0] * gx[0] + gy[0] * gy[0]));
        e.green = 8'(round_root(gx[1] * gx[1] + gy[1] * gy[1]));
        e.blue = 8'(round_root(gx[2] * gx[2] + gy[2] * gy[2]));
        e.row_end = (pc == w - 1);
        e.frame_end = (p == total - 1);
        edge_expected.push_back(e);
        if (p == total - 1) restart_frame();
    endfunction

    // input driver
    always @(posedge aclk) begin
        pixel_beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                b.req_type = s_req_type;
                b.red = s_in_red;
                b.green = s_in_green;
                b.blue = s_in_blue;
                predict_edge(b);
            end
            if (!s_valid || s_ready) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle) begin
                    b = pending_pixels.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= b.req_type;
                    s_in_red <= b.red;
                    s_in_green <= b.green;
                    s_in_blue <= b.blue;
                    items_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        edge_beat_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
            if (m_valid && m_ready) begin
                if (edge_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected edge beat r=%0d g=%0d b=%0d", m_edge_red,
                                 m_edge_green, m_edge_blue);
                end else begin
                    e = edge_expected.pop_front();
                    edges_checked++;
                    if (m_frame_end) frames_closed++;
                    if (m_edge_red !== e.red || m_edge_green !== e.green
                        || m_edge_blue !== e.blue || m_row_end !== e.row_end
                        || m_frame_end !== e.frame_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("edge beat %0d: expected %0d %0d %0d re=%0d fe=%0d, got %0d %0d %0d re=%0d fe=%0d",
                                     edges_checked, e.red, e.green, e.blue, e.row_end,
                                     e.frame_end, m_edge_red, m_edge_green, m_edge_blue,
                                     m_row_end, m_frame_end);
                    end
                end
            end
        end
    end

    task automatic wait_quiet();
        while (pending_pixels.size() != 0 || s_valid || edge_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic reg_sel, int value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == sem_pkg::REG_WIDTH) cfg_width = value & 'h7ff;
        else cfg_height = value & 'hfff;
        restart_frame();
        config_writes++;
    endtask

    task automatic set_size(int w, int h);
        wait_quiet();
        write_reg(sem_pkg::REG_WIDTH, w);
        write_reg(sem_pkg::REG_HEIGHT, h);
    endtask

    task automatic push_beat(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_beat_t x;
        x.req_type = req;
        x.red = r;
        x.green = g;
        x.blue = b;
        pending_pixels.push_back(x);
    endtask

    task automatic push_random_pixel();
        if ($urandom_range(7) == 0)
            push_beat(sem_pkg::REQ_PIXEL, $urandom_range(1) ? 8'hff : 8'h00,
                      $urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00);
        else
            push_beat(sem_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // one frame with random content, sometimes broken
    task automatic push_frame(int w, int h);
        int n, cut;
        bit broken;
        n = w * h;
        broken = ($urandom_range(9) == 0);
        cut = broken ? $urandom_range(n) : n;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(29) == 0)
                push_beat(sem_pkg::REQ_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            push_random_pixel();
        end
        if (broken) begin
            set_size(w, h);
            return;
        end
        for (int i = 0; i <= w; i++) begin
            if ($urandom_range(5) == 0) push_random_pixel();
            else push_beat(sem_pkg::REQ_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int w, h, phase;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_in_red = 8'h0;
        s_in_green = 8'h0;
        s_in_blue = 8'h0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'h0;
        pwdata = 32'h0;
        for (int i = 0; i < RING; i++) line_ring[i] = 24'h0;
        cfg_width = 1024;
        cfg_height = 768;
        restart_frame();
        send_idle = 20;
        recv_idle = 48;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size, a few pixels, then aborted by a register write
        push_beat(sem_pkg::REQ_PIXEL, 8'hff, 8'h00, 8'hff);
        push_beat(sem_pkg::REQ_PIXEL, 8'h00, 8'hff, 8'h00);
        push_beat(sem_pkg::REQ_PIXEL, 8'hff, 8'hff, 8'hff);
        set_size(1, 1);
        // early drain is ignored
        push_beat(sem_pkg::REQ_DRAIN, 8'h12, 8'h34, 8'h56);
        push_beat(sem_pkg::REQ_PIXEL, 8'hff, 8'h00, 8'hff);
        push_beat(sem_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);
        push_beat(sem_pkg::REQ_DRAIN, 8'hff, 8'hff, 8'hff);
        // zero size acts as one, surplus pixel acts as drain
        set_size(0, 0);
        push_beat(sem_pkg::REQ_PIXEL, 8'h80, 8'h7f, 8'h01);
        push_beat(sem_pkg::REQ_PIXEL, 8'hff, 8'hff, 8'hff);
        push_beat(sem_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);
        // oversize width and largest height, aborted
        set_size(2047, 4095);
        push_beat(sem_pkg::REQ_PIXEL, 8'hff, 8'hff, 8'hff);
        push_beat(sem_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        set_size(3, 2);
        for (int i = 0; i < 6; i++)
            push_beat(sem_pkg::REQ_PIXEL, i[0] ? 8'hff : 8'h00, i[0] ? 8'h00 : 8'hff, 8'hff);
        push_beat(sem_pkg::REQ_PIXEL, 8'h55, 8'haa, 8'h55);
        for (int i = 0; i < 3; i++) push_beat(sem_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00);

        w = 3;
        h = 2;
        phase = 0;
        while (items_sent + pending_pixels.size() < 1550) begin
            if (phase == 0 && items_sent > 560) begin
                wait_quiet();
                send_idle = 48;
                recv_idle = 20;
                phase = 1;
            end else if (phase == 1 && items_sent > 1100) begin
                wait_quiet();
                send_idle = 0;
                recv_idle = 0;
                phase = 2;
            end
            if ($urandom_range(2) == 0) begin
                w = ($urandom_range(29) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 9);
                h = $urandom_range(1, 6);
                set_size(w, h);
            end
            push_frame(w, h);
        end

        wait_quiet();
        $display("%0d beats in, %0d edge beats checked over %0d frames, %0d register writes",
                 items_sent, edges_checked, frames_closed, config_writes);
        if (mismatches == 0 && !timed_out) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(12 * 2000000);
        timed_out = 1'b1;
        $display("simulation failed");
        $finish;
    end
endmodule
